// ----- sv/msap_pkg.sv -----
`default_nettype none
package msap_pkg;

    localparam int SEQ_BITS   = 12;
    localparam int SUM_BITS   = 24;
    localparam int OFS_BITS   = 12;
    localparam int WIN_BITS   = 12;
    localparam int FS_BITS    = 16;
    localparam int CUR_BITS   = 21;
    localparam int DEM_BITS   = 16;
    localparam int DUTY_BITS  = 16;
    localparam int POS_BITS   = 32;
    localparam int HALL_BITS  = 3;
    localparam int MAX_CH     = 3;
    localparam int UNIT_SHIFT = 14;

    localparam int CUR_MAX = 1048575;
    localparam int CUR_MIN = -1048576;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_OFFSET_A   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_OFFSET_B   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_OFFSET_C   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_WINDOW = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FULL_SCALE = 3'd4;

    localparam logic [WIN_BITS-1:0] MAX_WINDOW_RST = 12'd450;
    localparam logic [FS_BITS-1:0]  FULL_SCALE_RST = 16'd5000;

    // input request layout
    localparam int IN_SEQ_LSB   = 0;
    localparam int IN_SUM_LSB   = IN_SEQ_LSB + SEQ_BITS;
    localparam int IN_POS_LSB   = IN_SUM_LSB + MAX_CH * SUM_BITS;
    localparam int IN_IDX_LSB   = IN_POS_LSB + POS_BITS;
    localparam int IN_CNT_LSB   = IN_IDX_LSB + POS_BITS;
    localparam int IN_HALL_LSB  = IN_CNT_LSB + POS_BITS;
    localparam int IN_DEM_LSB   = IN_HALL_LSB + HALL_BITS;
    localparam int IN_EN_LSB    = IN_DEM_LSB + MAX_CH * DEM_BITS;
    localparam int S_TDATA_BITS = 240;
    localparam int M_TDATA_BITS = 216;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } lane_ctrl_t;

    typedef struct packed {
        logic                  fresh;
        logic [POS_BITS-1:0]   rel_pos;
        logic [POS_BITS-1:0]   rel_idx;
        logic [POS_BITS-1:0]   index_events;
        logic [HALL_BITS-1:0]  hall_sector;
        logic [MAX_CH-1:0]     drive;
    } item_t;

    function automatic logic [HALL_BITS-1:0] hall_sector_of(input logic [HALL_BITS-1:0] code);
        logic [HALL_BITS-1:0] s;
        case (code)
            3'd1:    s = 3'd0;
            3'd5:    s = 3'd1;
            3'd4:    s = 3'd2;
            3'd6:    s = 3'd3;
            3'd2:    s = 3'd4;
            3'd3:    s = 3'd5;
            default: s = 3'd7;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- sv/motor_sensor_average_and_pwm.sv -----
`default_nettype none
// Flow: a request accepted in ST_IDLE is divided in ST_CALC, where the lane dividers
//   produce one quotient bit per cycle; the result waits in ST_WAIT for the output register.
// Requests: a new request is taken only in ST_IDLE, once the previous result is loaded, as
//   each channel lane's bit-serial divider is busy; the output register holds the result.
// Reset: aresetn synchronous active low; clears sequence, sums, held currents, position
//   origin and config registers to their defaults. No clearing pass.
module motor_sensor_average_and_pwm import msap_pkg::*; #(
    parameter int CHANNELS  = 3,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // adc_sequence, sum_a, sum_b, sum_c, encoder_position, index_position,
    // index_count, hall_code, demand_a, demand_b, demand_c, drive_enables, zero fill
    input  wire logic [S_TDATA_BITS-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // current_a, current_b, current_c, rel_position, rel_index_position,
    // index_events, hall_sector, duty_a, duty_b, duty_c, drive_state, zero fill
    output logic [M_TDATA_BITS-1:0]        m_axis_tdata,
    // current_fresh
    output logic [0:0]                     m_axis_tuser,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int DW        = SUM_BITS + FRAC_BITS;
    localparam int CNT_BITS  = $clog2(DW);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DW - 1);
    localparam logic [MAX_CH-1:0]   CH_MASK  = MAX_CH'((1 << CHANNELS) - 1);

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [OFS_BITS-1:0]   offset_reg [MAX_CH];
    logic [WIN_BITS-1:0]   max_window_reg;
    logic [FS_BITS-1:0]    full_scale_reg;
    logic [SEQ_BITS-1:0]   last_seq_reg;
    logic [SUM_BITS-1:0]   last_sum_reg [MAX_CH];
    logic [POS_BITS-1:0]   pos_off_reg;
    logic                  primed_reg;
    item_t                 item_reg;

    logic                  in_fire, load, out_free;
    lane_ctrl_t            lane_ctrl;
    logic [SEQ_BITS-1:0]   seq, d;
    logic                  fresh;
    logic [SUM_BITS-1:0]   sum_in   [MAX_CH];
    logic [SUM_BITS-1:0]   sum_diff [MAX_CH];
    logic [POS_BITS-1:0]   pos, idx, pos_base;
    logic [MAX_CH-1:0]     en;

    logic [MAX_CH-1:0][CUR_BITS-1:0]  lane_cur;
    logic [MAX_CH-1:0][DUTY_BITS-1:0] lane_duty;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        seq      = s_axis_tdata[IN_SEQ_LSB +: SEQ_BITS];
        pos      = s_axis_tdata[IN_POS_LSB +: POS_BITS];
        idx      = s_axis_tdata[IN_IDX_LSB +: POS_BITS];
        en       = s_axis_tdata[IN_EN_LSB +: MAX_CH] & CH_MASK;
        d        = seq - last_seq_reg;
        fresh    = (d > SEQ_BITS'(1)) && (d <= max_window_reg);
        pos_base = primed_reg ? pos_off_reg : pos;
        for (int ch = 0; ch < MAX_CH; ch++) begin
            sum_in[ch]   = s_axis_tdata[IN_SUM_LSB + ch*SUM_BITS +: SUM_BITS];
            sum_diff[ch] = sum_in[ch] - last_sum_reg[ch];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_CALC;
            end
            ST_CALC: begin
                if (cnt_reg == CNT_LAST) state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready   = 1'b0;
        lane_ctrl.step  = 1'b0;
        load            = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready  = aresetn;
            ST_CALC: lane_ctrl.step = 1'b1;
            ST_WAIT: load           = out_free;
            default: ;
        endcase
        lane_ctrl.start = in_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            offset_reg     <= '{default: '0};
            max_window_reg <= MAX_WINDOW_RST;
            full_scale_reg <= FULL_SCALE_RST;
            last_seq_reg   <= '0;
            last_sum_reg   <= '{default: '0};
            pos_off_reg    <= '0;
            primed_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_fire) begin
                cnt_reg      <= '0;
                last_seq_reg <= seq;
                last_sum_reg <= sum_in;
                pos_off_reg  <= pos_base;
                primed_reg   <= 1'b1;
            end else if (state_reg == ST_CALC) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_OFFSET_A:   offset_reg[0]  <= cfg_wdata[OFS_BITS-1:0];
                    CFG_OFFSET_B:   offset_reg[1]  <= cfg_wdata[OFS_BITS-1:0];
                    CFG_OFFSET_C:   offset_reg[2]  <= cfg_wdata[OFS_BITS-1:0];
                    CFG_MAX_WINDOW: max_window_reg <= cfg_wdata[WIN_BITS-1:0];
                    CFG_FULL_SCALE: full_scale_reg <= cfg_wdata[FS_BITS-1:0];
                    default: ;
                endcase
            end
        end
        if (in_fire) begin
            item_reg.fresh        <= fresh;
            item_reg.rel_pos      <= pos - pos_base;
            item_reg.rel_idx      <= idx - pos_base;
            item_reg.index_events <= s_axis_tdata[IN_CNT_LSB +: POS_BITS];
            item_reg.hall_sector  <= hall_sector_of(s_axis_tdata[IN_HALL_LSB +: HALL_BITS]);
            item_reg.drive        <= en;
        end
    end

    for (genvar ch = 0; ch < MAX_CH; ch++) begin : g_lane
        if (ch < CHANNELS) begin : g_on
            msap_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .aclk       (aclk),
                .ctrl       (lane_ctrl),
                .sum_diff   (sum_diff[ch]),
                .divisor    (d),
                .offset     (offset_reg[ch]),
                .demand     (s_axis_tdata[IN_DEM_LSB + ch*DEM_BITS +: DEM_BITS]),
                .enable     (en[ch]),
                .full_scale (full_scale_reg),
                .current    (lane_cur[ch]),
                .duty       (lane_duty[ch])
            );
        end else begin : g_off
            assign lane_cur[ch]  = '0;
            assign lane_duty[ch] = '0;
        end
    end

    msap_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .item          (item_reg),
        .lane_cur      (lane_cur),
        .lane_duty     (lane_duty),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ap_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_CALC) && (cnt_reg == '0))
        else $error("request did not start the dividers");
    ap_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) && (cnt_reg == CNT_LAST) |=> state_reg == ST_WAIT)
        else $error("divide did not end after the last step");
    ap_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free && (state_reg == ST_WAIT))
        else $error("result loaded over a pending one");

endmodule
`default_nettype wire

// ----- sv/msap_lane.sv -----
`default_nettype none
module msap_lane import msap_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire lane_ctrl_t            ctrl,
    input  wire logic [SUM_BITS-1:0]   sum_diff,
    input  wire logic [SEQ_BITS-1:0]   divisor,
    input  wire logic [OFS_BITS-1:0]   offset,
    input  wire logic [DEM_BITS-1:0]   demand,
    input  wire logic                  enable,
    input  wire logic [FS_BITS-1:0]    full_scale,
    output logic      [CUR_BITS-1:0]   current,
    output logic      [DUTY_BITS-1:0]  duty
);

    localparam int DW        = SUM_BITS + FRAC_BITS;
    localparam int VW        = DW + 2;
    localparam int PROD_BITS = DEM_BITS - 1 + FS_BITS;
    localparam int SH_BITS   = PROD_BITS - UNIT_SHIFT;
    localparam logic signed [VW-1:0] V_MAX = VW'(CUR_MAX);
    localparam logic signed [VW-1:0] V_MIN = VW'(CUR_MIN);

    logic [SEQ_BITS-1:0]  div_reg;
    logic [SEQ_BITS-1:0]  rem_reg, rem_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic [DEM_BITS-1:0]  demand_reg;
    logic                 on_reg;
    logic [PROD_BITS-1:0] prod_reg;

    logic [SEQ_BITS:0]    trial, diff;
    logic                 take;
    logic signed [VW-1:0] value;
    logic [SH_BITS-1:0]   prod_sh;

    // restoring divider, one quotient bit per step
    always_comb begin
        trial    = {rem_reg, quo_reg[DW-1]};
        diff     = trial - {1'b0, div_reg};
        take     = trial >= {1'b0, div_reg};
        rem_next = take ? diff[SEQ_BITS-1:0] : trial[SEQ_BITS-1:0];
        quo_next = {quo_reg[DW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            div_reg    <= divisor;
            rem_reg    <= '0;
            quo_reg    <= DW'(sum_diff) << FRAC_BITS;
            demand_reg <= demand;
            on_reg     <= enable;
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        prod_reg <= PROD_BITS'(demand_reg[DEM_BITS-2:0]) * PROD_BITS'(full_scale);
    end

    always_comb begin
        value = $signed({2'b00, quo_reg}) - $signed(VW'(offset) << FRAC_BITS);
        if (value > V_MAX) begin
            current = V_MAX[CUR_BITS-1:0];
        end else if (value < V_MIN) begin
            current = V_MIN[CUR_BITS-1:0];
        end else begin
            current = value[CUR_BITS-1:0];
        end
    end

    always_comb begin
        prod_sh = prod_reg[PROD_BITS-1:UNIT_SHIFT];
        if (!on_reg || demand_reg[DEM_BITS-1]) begin
            duty = '0;
        end else if (prod_sh > SH_BITS'(full_scale)) begin
            duty = full_scale;
        end else begin
            duty = prod_sh[DUTY_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- sv/msap_merge.sv -----
`default_nettype none
module msap_merge import msap_pkg::*; (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              load,
    input  wire item_t                             item,
    input  wire logic [MAX_CH-1:0][CUR_BITS-1:0]   lane_cur,
    input  wire logic [MAX_CH-1:0][DUTY_BITS-1:0]  lane_duty,
    output logic                                   out_free,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // current_a, current_b, current_c, rel_position, rel_index_position,
    // index_events, hall_sector, duty_a, duty_b, duty_c, drive_state, zero fill
    output logic [M_TDATA_BITS-1:0]                m_axis_tdata,
    // current_fresh
    output logic [0:0]                             m_axis_tuser
);

    logic [MAX_CH-1:0][CUR_BITS-1:0] held_reg;
    logic [MAX_CH-1:0][CUR_BITS-1:0] cur_sel;
    logic                            valid_reg;
    logic [M_TDATA_BITS-1:0]         data_reg, data_next;
    logic                            fresh_reg;

    assign out_free = !valid_reg || m_axis_tready;
    assign cur_sel  = item.fresh ? lane_cur : held_reg;

    always_comb begin
        data_next = M_TDATA_BITS'({item.drive, lane_duty[2], lane_duty[1], lane_duty[0],
                                   item.hall_sector, item.index_events, item.rel_idx,
                                   item.rel_pos, cur_sel[2], cur_sel[1], cur_sel[0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            held_reg  <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                if (item.fresh) begin
                    held_reg <= lane_cur;
                end
            end else if (m_axis_tready) begin
                valid_reg <= 1'b0;
            end
        end
        if (load) begin
            data_reg  <= data_next;
            fresh_reg <= item.fresh;
        end
    end

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = data_reg;
    assign m_axis_tuser[0] = fresh_reg;

    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !item.fresh |=> $stable(held_reg))
        else $error("held currents changed on a stale request");
    ap_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_axis_tvalid)
        else $error("loaded result not presented");
    ap_rose: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(load))
        else $error("result valid without a load");

endmodule
`default_nettype wire
